@@ rtl/imhq_pkg.sv @@
package imhq_pkg;
   localparam int DEF_HEAP_CAPACITY = 1024;
   localparam int DEF_NODE_COUNT = 1024;
   localparam int DEF_KEY_BITS = 32;
   localparam int NODE_BITS = 10;
   localparam int IN_KEY_BITS = 32;
   localparam int COUNT_BITS = 11;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;
endpackage

@@ rtl/indexed_min_heap_queue_unit.sv @@
// Indexed binary min-heap with decrease-key. Pulse start while busy is low;
// a single-cycle rsp_valid strobe later carries the result, which the
// receiver cannot stall. Sift-up walks each level as a parent read, then a
// compare and move; sift-down as two child reads, then a compare and move.
// An insert or update also does the map lookup and setup, and every
// operation ends with the closing root read; an insert into a full heap or
// an extract from an empty one skips the sift. The steps are set by one slot
// memory that is read or written once per cycle. After reset the node map is
// cleared one entry per cycle, with busy held high meanwhile.
module indexed_min_heap_queue_unit
   import imhq_pkg::*;
#(
   parameter int HeapCapacity = DEF_HEAP_CAPACITY,
   parameter int NodeCount = DEF_NODE_COUNT,
   parameter int KeyBits = DEF_KEY_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_op,
   input  logic [NODE_BITS-1:0] req_node_id,
   input  logic [IN_KEY_BITS-1:0] req_cost_key,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic [NODE_BITS-1:0] rsp_out_node,
   output logic [IN_KEY_BITS-1:0] rsp_out_key,
   output logic [COUNT_BITS-1:0] rsp_entry_count,
   output logic [IN_KEY_BITS-1:0] rsp_min_key
);
   localparam int SB = $clog2(HeapCapacity + 1);
   localparam int NB = $clog2(NodeCount);
   localparam int IB = NODE_BITS;

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001, S_IDLE = 12'b000000000010,
      S_MAP = 12'b000000000100, S_DEC = 12'b000000001000,
      S_RROOT = 12'b000000010000, S_RLAST = 12'b000000100000,
      S_UPRD = 12'b000001000000, S_UPCMP = 12'b000010000000,
      S_DNRD = 12'b000100000000, S_DNR2 = 12'b001000000000,
      S_DNCMP = 12'b010000000000, S_DONE = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   // slot memory (ids and keys) and node map
   logic [IB-1:0] ids_mem [1:HeapCapacity];
   logic [KeyBits-1:0] keys_mem [1:HeapCapacity];
   logic [SB-1:0] map_mem [0:NodeCount-1];

   logic [SB-1:0] fill_ff, fill_in, pos_ff, pos_in;
   logic [NB:0] clr_ff, clr_in;
   logic [IB-1:0] nid_ff, nid_in, rid_ff, bid_ff, bid_in;
   logic [KeyBits-1:0] key_ff, key_in, rkey_ff, bkey_ff, bkey_in;
   logic [1:0] st_ff, st_in;
   logic [IB-1:0] onode_ff, onode_in;
   logic [KeyBits-1:0] okey_ff, okey_in;
   logic rv_ff;

   // memory port controls
   logic s_rd, s_we, m_we, m_rd;
   logic [SB-1:0] s_ra, s_wa, m_wd;
   logic [IB-1:0] s_wid, m_addr_id;
   logic [KeyBits-1:0] s_wk;
   logic [SB-1:0] map_rd_ff;

   always_ff @(posedge clock) begin
      if (s_we) begin
         ids_mem[s_wa] <= s_wid;
         keys_mem[s_wa] <= s_wk;
      end
      if (s_rd) begin
         rid_ff <= ids_mem[s_ra];
         rkey_ff <= keys_mem[s_ra];
      end
      if (m_we) map_mem[m_addr_id[NB-1:0]] <= m_wd;
      if (m_rd) map_rd_ff <= map_mem[nid_ff[NB-1:0]];
   end

   logic [SB:0] c2;
   assign c2 = {pos_ff, 1'b0};

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; pos_in = pos_ff;
      clr_in = clr_ff; nid_in = nid_ff; key_in = key_ff;
      st_in = st_ff; onode_in = onode_ff; okey_in = okey_ff;
      bid_in = bid_ff; bkey_in = bkey_ff;
      s_rd = 1'b0; s_we = 1'b0; m_we = 1'b0; m_rd = 1'b0;
      s_ra = pos_ff; s_wa = pos_ff; s_wid = nid_ff; s_wk = key_ff;
      m_addr_id = nid_ff; m_wd = pos_ff;
      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_addr_id = IB'(clr_ff); m_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (NB+1)'(NodeCount - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start && !busy) begin
               nid_in = req_node_id;
               key_in = KeyBits'(req_cost_key);
               st_in = ST_OK; onode_in = '0; okey_in = '0;
               state_in = S_MAP;
               if (req_op == OP_EXTRACT) begin
                  if (fill_ff == '0) begin
                     st_in = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     state_in = S_RROOT;
                  end
               end else if (32'(req_node_id) >= NodeCount) begin
                  state_in = S_DONE;
               end
            end
         end
         S_MAP: begin
            m_rd = 1'b1; state_in = S_DEC;
         end
         S_DEC: begin
            if (map_rd_ff != '0) begin
               pos_in = map_rd_ff; state_in = S_UPRD;
            end else if (32'(fill_ff) >= HeapCapacity) begin
               st_in = ST_FULL; state_in = S_DONE;
            end else begin
               fill_in = fill_ff + 1'b1; pos_in = fill_ff + 1'b1; state_in = S_UPRD;
            end
         end
         // sift up: hold entry in nid/key, read parent
         S_UPRD: begin
            if (pos_ff == SB'(1)) begin
               s_we = 1'b1; m_we = 1'b1; state_in = S_DONE;
            end else begin
               s_rd = 1'b1; s_ra = pos_ff >> 1; state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (key_ff < rkey_ff) begin
               // parent moves down
               s_we = 1'b1; s_wid = rid_ff; s_wk = rkey_ff;
               m_we = 1'b1; m_addr_id = rid_ff;
               pos_in = pos_ff >> 1; state_in = S_UPRD;
            end else begin
               s_we = 1'b1; m_we = 1'b1; state_in = S_DONE;
            end
         end
         S_RROOT: begin
            s_rd = 1'b1; s_ra = SB'(1); state_in = S_RLAST;
         end
         S_RLAST: begin
            onode_in = rid_ff; okey_in = rkey_ff;
            m_we = 1'b1; m_addr_id = rid_ff; m_wd = '0;
            s_rd = 1'b1; s_ra = fill_ff;
            fill_in = fill_ff - 1'b1; pos_in = SB'(1);
            state_in = S_DNRD;
         end
         // sift down: held entry goes in nid/key, left child in bid/bkey
         S_DNRD: begin
            // at the root the former last entry becomes the held entry
            if (pos_ff == SB'(1)) begin
               nid_in = rid_ff; key_in = rkey_ff;
            end
            state_in = S_DNR2;
            if (fill_ff == '0) state_in = S_DONE;
            else if ((SB+1)'(c2) > (SB+1)'(fill_ff)) begin
               s_we = 1'b1; m_we = 1'b1;
               if (pos_ff == SB'(1)) begin
                  s_wid = rid_ff; s_wk = rkey_ff; m_addr_id = rid_ff;
               end
               state_in = S_DONE;
            end else begin
               s_rd = 1'b1; s_ra = c2[SB-1:0];
            end
         end
         S_DNR2: begin
            bid_in = rid_ff; bkey_in = rkey_ff;
            if ((SB+1)'(c2) + 1'b1 <= (SB+1)'(fill_ff)) begin
               s_rd = 1'b1; s_ra = c2[SB-1:0] + 1'b1;
               state_in = S_DNCMP;
            end else begin
               state_in = S_DNCMP;
            end
         end
         S_DNCMP: begin
            // left child in bid, right child (if any) in rid
            logic rok;
            rok = ((SB+1)'(c2) + 1'b1 <= (SB+1)'(fill_ff));
            if (rok && !(bkey_ff < rkey_ff) && rkey_ff <= key_ff) begin
               s_we = 1'b1; s_wid = rid_ff; s_wk = rkey_ff;
               m_we = 1'b1; m_addr_id = rid_ff;
               pos_in = c2[SB-1:0] + 1'b1; state_in = S_DNRD;
            end else if (bkey_ff <= key_ff) begin
               s_we = 1'b1; s_wid = bid_ff; s_wk = bkey_ff;
               m_we = 1'b1; m_addr_id = bid_ff;
               pos_in = c2[SB-1:0]; state_in = S_DNRD;
            end else begin
               s_we = 1'b1; m_we = 1'b1; state_in = S_DONE;
            end
         end
         S_DONE: begin
            s_rd = 1'b1; s_ra = SB'(1); state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; fill_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; fill_ff <= fill_in;
         rv_ff <= (state_ff == S_DONE);
      end
      pos_ff <= pos_in; nid_ff <= nid_in; key_ff <= key_in;
      st_ff <= st_in; onode_ff <= onode_in; okey_ff <= okey_in;
      bid_ff <= bid_in; bkey_ff <= bkey_in;
   end

   assign busy = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_out_node = onode_ff;
   assign rsp_out_key = IN_KEY_BITS'(okey_ff);
   assign rsp_entry_count = COUNT_BITS'(fill_ff);
   assign rsp_min_key = (fill_ff == '0) ? IN_KEY_BITS'({KeyBits{1'b1}})
                                        : IN_KEY_BITS'(rkey_ff);

   // no strobe while idle-waiting with nothing finished
   a_rv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE)) else $error("stray strobe");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= HeapCapacity) else $error("fill over capacity");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept without busy");
endmodule

@@ sim/indexed_min_heap_queue_unit_tb.sv @@
module indexed_min_heap_queue_unit_tb;
   import imhq_pkg::*;

   localparam int CAPACITY = DEF_HEAP_CAPACITY;
   localparam int NODES = DEF_NODE_COUNT;
   localparam int CYCLE_LIMIT = 800000;
   localparam int TAIL_CYCLES = 100;

   typedef struct {
      logic [1:0] status;
      logic [NODE_BITS-1:0] node;
      logic [IN_KEY_BITS-1:0] key;
      logic [COUNT_BITS-1:0] count;
      logic [IN_KEY_BITS-1:0] min_key;
   } heap_word_type;

   typedef struct {
      logic op;
      logic [NODE_BITS-1:0] node;
      logic [IN_KEY_BITS-1:0] key;
      bit typed;
      heap_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_INSERT;
   logic [NODE_BITS-1:0] req_node_id = '0;
   logic [IN_KEY_BITS-1:0] req_cost_key = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [NODE_BITS-1:0] rsp_out_node;
   logic [IN_KEY_BITS-1:0] rsp_out_key;
   logic [COUNT_BITS-1:0] rsp_entry_count;
   logic [IN_KEY_BITS-1:0] rsp_min_key;

   // shadow heap kept by the predictor
   logic [NODE_BITS-1:0] shadow_id [1:CAPACITY];
   logic [IN_KEY_BITS-1:0] shadow_key [1:CAPACITY];
   int slot_of [NODES];
   int shadow_fill = 0;

   heap_word_type pending_words [$];
   stim_row_type typed_rows [$];
   stim_row_type table_rows [$];
   int mismatches = 0;
   int cycles = 0;
   int n_items = 0;
   int n_pops = 0;
   int n_empty_pops = 0;
   int peak_fill = 0;
   bit burst = 1'b0;

   indexed_min_heap_queue_unit i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_node_id(req_node_id),
      .req_cost_key(req_cost_key),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_node(rsp_out_node),
      .rsp_out_key(rsp_out_key),
      .rsp_entry_count(rsp_entry_count),
      .rsp_min_key(rsp_min_key)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void swap_slots(int a, int b);
      logic [NODE_BITS-1:0] id;
      logic [IN_KEY_BITS-1:0] k;
      id = shadow_id[a];
      k = shadow_key[a];
      shadow_id[a] = shadow_id[b];
      shadow_key[a] = shadow_key[b];
      shadow_id[b] = id;
      shadow_key[b] = k;
      slot_of[shadow_id[a]] = a;
      slot_of[shadow_id[b]] = b;
   endfunction

   function automatic void bubble_up(int pos);
      while (pos > 1 && shadow_key[pos] < shadow_key[pos / 2]) begin
         swap_slots(pos, pos / 2);
         pos = pos / 2;
      end
   endfunction

   // sift down; on equal keys the child wins
   function automatic void bubble_down(int pos);
      int best;
      while (pos < shadow_fill) begin
         best = pos;
         if (2 * pos <= shadow_fill && shadow_key[2 * pos] <= shadow_key[best])
            best = 2 * pos;
         if (2 * pos + 1 <= shadow_fill && shadow_key[2 * pos + 1] <= shadow_key[best])
            best = 2 * pos + 1;
         if (best == pos)
            break;
         swap_slots(pos, best);
         pos = best;
      end
   endfunction

   function automatic heap_word_type heap_step(logic op, logic [NODE_BITS-1:0] node,
                                               logic [IN_KEY_BITS-1:0] key);
      heap_word_type w;
      int s;
      w.status = ST_OK;
      w.node = '0;
      w.key = '0;
      if (op == OP_INSERT) begin
         s = slot_of[node];
         if (s != 0) begin
            shadow_key[s] = key;
            bubble_up(s);
         end else if (shadow_fill >= CAPACITY) begin
            w.status = ST_FULL;
         end else begin
            shadow_fill++;
            shadow_id[shadow_fill] = node;
            shadow_key[shadow_fill] = key;
            slot_of[node] = shadow_fill;
            bubble_up(shadow_fill);
         end
      end else if (shadow_fill == 0) begin
         w.status = ST_EMPTY;
      end else begin
         w.node = shadow_id[1];
         w.key = shadow_key[1];
         slot_of[w.node] = 0;
         shadow_id[1] = shadow_id[shadow_fill];
         shadow_key[1] = shadow_key[shadow_fill];
         shadow_fill--;
         if (shadow_fill > 0) begin
            slot_of[shadow_id[1]] = 1;
            bubble_down(1);
         end
      end
      w.count = shadow_fill[COUNT_BITS-1:0];
      w.min_key = (shadow_fill == 0) ? '1 : shadow_key[1];
      return w;
   endfunction

   // accepted words feed the predictor, results are checked in order
   always @(posedge clock) begin
      heap_word_type w;
      stim_row_type r;
      cycles <= cycles + 1;
      if (!reset && start && !busy) begin
         r = typed_rows.pop_front();
         w = heap_step(req_op, req_node_id, req_cost_key);
         pending_words.push_back(r.typed ? r.want : w);
         n_items++;
         if (req_op == OP_EXTRACT) begin
            n_pops++;
            if (w.status == ST_EMPTY)
               n_empty_pops++;
         end
         if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
      end
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word at cycle %0d", cycles);
         end else begin
            w = pending_words.pop_front();
            if (rsp_status !== w.status || rsp_out_node !== w.node ||
                rsp_out_key !== w.key || rsp_entry_count !== w.count ||
                rsp_min_key !== w.min_key) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at cycle %0d: want st=%0d node=%0d key=%h cnt=%0d min=%h,",
                           " got st=%0d node=%0d key=%h cnt=%0d min=%h",
                           cycles, w.status, w.node, w.key, w.count, w.min_key,
                           rsp_status, rsp_out_node, rsp_out_key, rsp_entry_count,
                           rsp_min_key);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_words.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // drive one word; a zero gap keeps start high into the next word
   task automatic send_word(stim_row_type r);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_rows.push_back(r);
      start <= 1'b1;
      req_op <= r.op;
      req_node_id <= r.node;
      req_cost_key <= r.key;
      do @(posedge clock); while (busy);
      if (n_items % 60 == 0)
         burst = ($urandom_range(0, 3) == 0);
   endtask

   function automatic logic [IN_KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return $urandom_range(0, 1) ? '1 : '0;
         2: return {4'($urandom_range(0, 15)), 28'h0};
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type make_row(logic op, logic [NODE_BITS-1:0] node,
                                             logic [IN_KEY_BITS-1:0] key);
      stim_row_type r;
      r.op = op;
      r.node = node;
      r.key = key;
      r.typed = 1'b0;
      r.want = '{ST_OK, '0, '0, '0, '0};
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic op, logic [NODE_BITS-1:0] node,
                                              logic [IN_KEY_BITS-1:0] key,
                                              heap_word_type w);
      stim_row_type r;
      r = make_row(op, node, key);
      r.typed = 1'b1;
      r.want = w;
      return r;
   endfunction

   task automatic drain_and_hold();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      int order [NODES];
      int j, t;
      for (int n = 0; n < NODES; n++)
         slot_of[n] = 0;

      // directed words: empty pop, extremes, ties, decrease and raise of a key
      table_rows.push_back(typed_row(OP_EXTRACT, 10'd5, 32'h1234,
                                     '{ST_EMPTY, '0, '0, 11'd0, '1}));
      table_rows.push_back(typed_row(OP_INSERT, 10'd1023, '1,
                                     '{ST_OK, '0, '0, 11'd1, '1}));
      table_rows.push_back(typed_row(OP_INSERT, 10'd0, '0,
                                     '{ST_OK, '0, '0, 11'd2, '0}));
      table_rows.push_back(typed_row(OP_EXTRACT, 10'd0, '0,
                                     '{ST_OK, 10'd0, '0, 11'd1, '1}));
      table_rows.push_back(typed_row(OP_EXTRACT, 10'd0, '0,
                                     '{ST_OK, 10'd1023, '1, 11'd0, '1}));
      table_rows.push_back(typed_row(OP_EXTRACT, 10'd0, '0,
                                     '{ST_EMPTY, '0, '0, 11'd0, '1}));
      table_rows.push_back(make_row(OP_INSERT, 10'd5, 32'd100));
      table_rows.push_back(make_row(OP_INSERT, 10'd6, 32'd100));
      table_rows.push_back(make_row(OP_INSERT, 10'd7, 32'd50));
      table_rows.push_back(make_row(OP_INSERT, 10'd5, 32'd10));
      table_rows.push_back(make_row(OP_INSERT, 10'd7, 32'd900));
      table_rows.push_back(make_row(OP_INSERT, 10'd512, 32'h8000_0000));
      table_rows.push_back(make_row(OP_INSERT, 10'd341, 32'h5555_5555));
      table_rows.push_back(make_row(OP_INSERT, 10'd682, 32'hAAAA_AAAA));
      table_rows.push_back(make_row(OP_INSERT, 10'd8, 32'd100));
      for (int k = 0; k < 9; k++)
         table_rows.push_back(make_row(OP_EXTRACT, 10'h3FF, '1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[k])
         send_word(table_rows[k]);
      drain_and_hold();

      // few nodes: many updates, ties and empty pops
      for (int k = 0; k < 500; k++)
         send_word(make_row($urandom_range(0, 99) < 45,
                            NODE_BITS'($urandom_range(0, 15)), pick_key()));

      // fill to capacity in shuffled order, with some updates on the way
      for (int n = 0; n < NODES; n++)
         order[n] = n;
      for (int n = NODES - 1; n > 0; n--) begin
         j = $urandom_range(0, n);
         t = order[n];
         order[n] = order[j];
         order[j] = t;
      end
      for (int n = 0; n < NODES; n++) begin
         send_word(make_row(OP_INSERT, NODE_BITS'(order[n]), pick_key()));
         if (n % 16 == 0)
            send_word(make_row(OP_INSERT, NODE_BITS'(order[$urandom_range(0, n)]),
                               pick_key()));
      end
      // updates while full
      for (int k = 0; k < 60; k++)
         send_word(make_row(OP_INSERT, NODE_BITS'($urandom), pick_key()));
      drain_and_hold();

      // pops mixed with updates and reinserts
      for (int k = 0; k < 200; k++)
         send_word(make_row($urandom_range(0, 99) < 80, NODE_BITS'($urandom),
                            pick_key()));

      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d words sent, %0d pops (%0d on empty), heap depth reached %0d of %0d",
               n_items, n_pops, n_empty_pops, peak_fill, CAPACITY);
      $display("%0d mismatches in %0d cycles", mismatches, cycles);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/imhq_pkg.sv
rtl/indexed_min_heap_queue_unit.sv
sim/indexed_min_heap_queue_unit_tb.sv
